FILE: hdl/byte_escape_encoder_macros.svh
// ---------------------------------------------------------------------------
// Byte escape encoder assertion macros
// Shorthand for the concurrent checks of the encoder, clocked on clk and
// disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef BYTE_ESCAPE_ENCODER_MACROS_SVH
`define BYTE_ESCAPE_ENCODER_MACROS_SVH

// Overlapping implication: the consequent is checked from the same edge.
`define BEE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("byte escape encoder check failed");

// Non-overlapping implication: the consequent is checked from the next edge.
`define BEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("byte escape encoder check failed");

`endif

FILE: hdl/bee_pkg.sv
// ---------------------------------------------------------------------------
// Byte escape encoder package
// Shared types and constants for the classifier front, the queue and the
// output serializer.
// ---------------------------------------------------------------------------
package bee_pkg;

  // Escape rule selected by one mode slot.
  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_CSTYLE = 2'd1,
    MODE_REGEX  = 2'd2,
    MODE_HEX    = 2'd3
  } esc_mode_t;

  // Encoding chosen for one input byte.
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_SLASH = 2'd1,
    KIND_HEX   = 2'd2
  } esc_kind_t;

  // The three ordered mode slots.
  typedef struct packed {
    esc_mode_t first;
    esc_mode_t second;
    esc_mode_t third;
  } mode_slots_t;

  // One classified byte on its way to the serializer. For a backslash
  // escape the data is the character that follows the backslash; for a hex
  // escape it is the raw byte.
  typedef struct packed {
    esc_kind_t  kind;
    logic [7:0] data;
  } esc_entry_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLOT_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SLOT_SECOND = 2'd1;
  localparam logic [1:0] CFG_SLOT_THIRD  = 2'd2;

  // Output characters of the escape sequences.
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 2;

endpackage

FILE: hdl/byte_escape_encoder.sv
// An accepted byte is registered in the queue and then in the serializer's
// current entry before its first output byte shows. A plain byte yields one
// output byte, a backslash escape two and a hex escape four, one per transfer.
// Input bytes keep flowing every cycle while the queue has room.
// Reset (rst, synchronous) empties the queue and the serializer and sets
// all three mode slots to none.
// ---------------------------------------------------------------------------
// Byte escape encoder
// Escapes one byte of text per transfer in C-style, regex or hex form as
// chosen by three ordered mode slots.
// ---------------------------------------------------------------------------
`include "byte_escape_encoder_macros.svh"

module byte_escape_encoder
  import bee_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic [7:0] in_byte,
  input  logic       in_valid,
  output logic       in_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       out_valid,
  input  logic       out_stall
);

  mode_slots_t slots;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  esc_entry_t  q_in;
  esc_entry_t  q_head;

  // Mode slot registers; writes beyond the third slot are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= '{first: MODE_NONE, second: MODE_NONE, third: MODE_NONE};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLOT_FIRST:  slots.first  <= esc_mode_t'(cfg_data);
        CFG_SLOT_SECOND: slots.second <= esc_mode_t'(cfg_data);
        CFG_SLOT_THIRD:  slots.third  <= esc_mode_t'(cfg_data);
        default:         slots        <= slots;
      endcase
    end
  end

  bee_front u_front (
    .rst      (rst),
    .in_byte  (in_byte),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .slots    (slots),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  bee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  bee_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

  // A sequence that has not reached its last byte keeps going.
  `BEE_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !last_of_run, out_valid)

  // With a queued byte waiting, the next sequence starts right after the last one.
  `BEE_ASSERT_NEXT(a_no_bubble, out_valid && !out_stall && last_of_run && !q_empty, out_valid)

  // A transfer into an idle block reaches the output through the queue and the serializer's entry register.
  `BEE_ASSERT_IMPL(a_latency, in_valid && !in_stall && !out_valid && q_empty, ##2 out_valid)

endmodule

FILE: hdl/bee_front.sv
// ---------------------------------------------------------------------------
// Byte escape encoder front
// Accepts input bytes, applies the three mode slots in order and pushes the
// resulting escape kind and payload byte into the queue.
// ---------------------------------------------------------------------------
module bee_front
  import bee_pkg::*;
(
  input  logic        rst,
  input  logic [7:0]  in_byte,
  input  logic        in_valid,
  output logic        in_stall,
  input  mode_slots_t slots,
  input  logic        q_full,
  output logic        q_push,
  output esc_entry_t  q_entry
);

  // Tries one escape rule on a byte; a plain result carries the raw byte.
  function automatic esc_entry_t try_mode(esc_mode_t mode, logic [7:0] c);
    esc_entry_t e;
    e.kind = KIND_PLAIN;
    e.data = c;
    case (mode)
      MODE_CSTYLE: begin
        case (c) inside
          8'h0D: begin
            e.kind = KIND_SLASH;
            e.data = 8'h72;
          end
          8'h0A: begin
            e.kind = KIND_SLASH;
            e.data = 8'h6E;
          end
          8'h09: begin
            e.kind = KIND_SLASH;
            e.data = 8'h74;
          end
          8'h5C, 8'h27, 8'h22: e.kind = KIND_SLASH;
          default: e.kind = KIND_PLAIN;
        endcase
      end
      MODE_REGEX: begin
        case (c) inside
          8'h2E, 8'h24, 8'h5E, 8'h2A, 8'h5B, 8'h2D, 8'h5D, 8'h3C, 8'h3E,
          8'h28, 8'h29, 8'h7C, 8'h2B, 8'h3F, 8'h7B, 8'h2C, 8'h7D:
            e.kind = KIND_SLASH;
          default: e.kind = KIND_PLAIN;
        endcase
      end
      MODE_HEX: begin
        if (c < 8'h20 || c >= 8'h7F) begin
          e.kind = KIND_HEX;
        end
      end
      default: e.kind = KIND_PLAIN;
    endcase
    return e;
  endfunction

  esc_entry_t entry_first;
  esc_entry_t entry_second;
  esc_entry_t entry_third;

  // The first slot whose rule matches decides the encoding.
  always_comb begin
    entry_first  = try_mode(slots.first, in_byte);
    entry_second = try_mode(slots.second, in_byte);
    entry_third  = try_mode(slots.third, in_byte);
    if (entry_first.kind != KIND_PLAIN) begin
      q_entry = entry_first;
    end else if (entry_second.kind != KIND_PLAIN) begin
      q_entry = entry_second;
    end else begin
      q_entry = entry_third;
    end
  end

  // A transfer is taken whenever the queue has room and rst is low.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && !rst;

endmodule

FILE: hdl/bee_queue.sv
// ---------------------------------------------------------------------------
// Byte escape encoder queue
// Short first-in first-out buffer of classified bytes between the front and
// the serializer, so that each side can stall on its own.
// ---------------------------------------------------------------------------
module bee_queue
  import bee_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  esc_entry_t push_entry,
  input  logic       pop,
  output esc_entry_t head,
  output logic       full,
  output logic       empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  esc_entry_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Storage is written only on a push and needs no reset.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers wrap at the configured depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/bee_back.sv
// ---------------------------------------------------------------------------
// Byte escape encoder back
// Takes one classified byte at a time from the queue and emits its escaped
// sequence one output byte per transfer, marking the final byte.
// ---------------------------------------------------------------------------
module bee_back
  import bee_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  esc_entry_t q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       out_valid,
  input  logic       out_stall
);

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_digit(logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10) begin
      d = 8'h30 + {4'd0, n};
    end else begin
      d = 8'h57 + {4'd0, n};
    end
    return d;
  endfunction

  esc_entry_t cur;
  logic       cur_valid;
  logic [1:0] step;
  logic       take;
  logic       done;

  assign out_valid = cur_valid;
  assign take      = cur_valid && !out_stall;
  assign done      = !cur_valid || (take && last_of_run);
  assign q_pop     = done && !q_empty;

  // Output byte and end marker for the current step of the sequence.
  always_comb begin
    case (cur.kind)
      KIND_SLASH: begin
        out_byte    = (step == 2'd0) ? CH_BACKSLASH : cur.data;
        last_of_run = (step == 2'd1);
      end
      KIND_HEX: begin
        case (step)
          2'd0:    out_byte = CH_BACKSLASH;
          2'd1:    out_byte = CH_LOWER_X;
          2'd2:    out_byte = hex_digit(cur.data[7:4]);
          default: out_byte = hex_digit(cur.data[3:0]);
        endcase
        last_of_run = (step == 2'd3);
      end
      default: begin
        out_byte    = cur.data;
        last_of_run = 1'b1;
      end
    endcase
  end

  // Load the next entry when the current sequence ends, else advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= 2'd0;
    end else if (done) begin
      cur_valid <= !q_empty;
      step      <= 2'd0;
    end else if (take) begin
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Byte escape encoder testbench
// Streams text bytes through the encoder under a series of mode slot
// settings. Each accepted byte is escaped by a local predictor. Every
// output transfer is checked against the oldest predicted byte. Both
// sides idle at random, and in one phase the output side holds off for a
// long stretch.
// ---------------------------------------------------------------------------
module tb_top;
  import bee_pkg::*;

  // Register index that the encoder must ignore.
  localparam logic [1:0] CFG_INDEX_SPARE = 2'd3;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int SETTLE_CYCLES  = 6;

  // One predicted output byte.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } esc_out_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [1:0] cfg_data = '0;
  logic [7:0] in_byte = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       out_valid;
  logic       out_stall = 1'b0;

  // Local copy of the mode slots.
  esc_mode_t slot_first  = MODE_NONE;
  esc_mode_t slot_second = MODE_NONE;
  esc_mode_t slot_third  = MODE_NONE;

  logic [7:0] text_q[$];
  esc_out_t   escaped_q[$];
  int         mismatches = 0;

  // Idling controls, set between phases.
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int sink_pick;
  int idle_cycles = 0;

  // Bytes that trigger one of the escape rules or sit on a class boundary.
  logic [7:0] hot_bytes [30] = '{
    8'h0D, 8'h0A, 8'h09, 8'h5C, 8'h27, 8'h22,
    8'h2E, 8'h24, 8'h5E, 8'h2A, 8'h5B, 8'h2D, 8'h5D, 8'h3C, 8'h3E, 8'h28,
    8'h29, 8'h7C, 8'h2B, 8'h3F, 8'h7B, 8'h2C, 8'h7D,
    8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'hFF
  };

  byte_escape_encoder i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_byte     (in_byte),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Text byte biased toward the characters that the rules care about.
  function automatic logic [7:0] pick_text_byte();
    if ($urandom_range(0, 99) < 45) return hot_bytes[$urandom_range(0, 29)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h61 + 8'(nib) - 8'd10;
  endfunction

  // Tests one rule against a byte; follow is the character after the
  // backslash when a backslash escape applies.
  function automatic esc_kind_t rule_match(esc_mode_t m, logic [7:0] c,
                                           output logic [7:0] follow);
    follow = c;
    case (m)
      MODE_CSTYLE: begin
        case (c)
          8'h0D: begin
            follow = "r";
            return KIND_SLASH;
          end
          8'h0A: begin
            follow = "n";
            return KIND_SLASH;
          end
          8'h09: begin
            follow = "t";
            return KIND_SLASH;
          end
          8'h5C, 8'h27, 8'h22: return KIND_SLASH;
          default: return KIND_PLAIN;
        endcase
      end
      MODE_REGEX: begin
        case (c)
          ".", "$", "^", "*", "[", "-", "]", "<", ">", "(", ")", "|", "+", "?",
          "{", ",", "}": return KIND_SLASH;
          default: return KIND_PLAIN;
        endcase
      end
      MODE_HEX: begin
        if (c < 8'h20 || c >= 8'h7F) return KIND_HEX;
        return KIND_PLAIN;
      end
      default: return KIND_PLAIN;
    endcase
  endfunction

  // Escapes one accepted byte and queues the output bytes it must produce.
  function automatic void predict_escape(logic [7:0] raw);
    esc_mode_t  order [3];
    esc_kind_t  kind;
    logic [7:0] follow;
    order = '{slot_first, slot_second, slot_third};
    kind = KIND_PLAIN;
    follow = raw;
    for (int s = 0; s < 3 && kind == KIND_PLAIN; s++) begin
      kind = rule_match(order[s], raw, follow);
    end
    case (kind)
      KIND_HEX: begin
        escaped_q.push_back('{CH_BACKSLASH, 1'b0});
        escaped_q.push_back('{CH_LOWER_X, 1'b0});
        escaped_q.push_back('{hex_char(raw[7:4]), 1'b0});
        escaped_q.push_back('{hex_char(raw[3:0]), 1'b1});
      end
      KIND_SLASH: begin
        escaped_q.push_back('{CH_BACKSLASH, 1'b0});
        escaped_q.push_back('{follow, 1'b1});
      end
      default: escaped_q.push_back('{raw, 1'b1});
    endcase
  endfunction

  function automatic void note_mismatch(string what, esc_out_t want, esc_out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch (%s): expected byte %h last %b, got byte %h last %b",
               what, want.data, want.last, got.data, got.last);
    end
  endfunction

  // Compares one output transfer with the oldest predicted byte.
  function automatic void check_output(logic [7:0] b, logic last);
    esc_out_t got;
    esc_out_t want;
    got = '{b, last};
    if (escaped_q.size() == 0) begin
      note_mismatch("unexpected output", '0, got);
    end else begin
      want = escaped_q.pop_front();
      if (want.data !== got.data || want.last !== got.last) begin
        note_mismatch("wrong output", want, got);
      end
    end
  endfunction

  // Input driver: offers queued text bytes, holding each one while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_escape(in_byte);
      end
      if (in_valid && in_stall) begin
        // The stalled byte stays on the port.
      end else if (src_gap != 0) begin
        src_gap <= src_gap - 1;
        in_valid <= 1'b0;
      end else if (text_q.size() != 0) begin
        in_byte <= text_q.pop_front();
        in_valid <= 1'b1;
        src_gap <= src_idle_on ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor: checks each transfer and drives random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      sink_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_output(out_byte, last_of_run);
      end
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        out_stall <= 1'b1;
      end else begin
        sink_pick = sink_idle_on ? pick_gap() : 0;
        if (sink_pick != 0) begin
          sink_gap <= sink_pick - 1;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Writes one mode slot register and updates the local copy.
  task automatic write_slot(logic [1:0] idx, esc_mode_t m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SLOT_FIRST:  slot_first = m;
      CFG_SLOT_SECOND: slot_second = m;
      CFG_SLOT_THIRD:  slot_third = m;
      default: ;
    endcase
  endtask

  // Waits until every byte is sent and every output byte has arrived.
  task automatic drain();
    while (text_q.size() != 0 || in_valid || escaped_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sets up the slots and idling, queues random text and drains it.
  task automatic run_phase(esc_mode_t a, esc_mode_t b, esc_mode_t c, int n_bytes,
                           bit src_idle, bit sink_idle, bit spare_write, bit long_hold);
    write_slot(CFG_SLOT_FIRST, a);
    write_slot(CFG_SLOT_SECOND, b);
    write_slot(CFG_SLOT_THIRD, c);
    if (spare_write) write_slot(CFG_INDEX_SPARE, esc_mode_t'($urandom_range(0, 3)));
    @(negedge clk);
    src_idle_on = src_idle;
    sink_idle_on = sink_idle;
    for (int k = 0; k < n_bytes; k++) text_q.push_back(pick_text_byte());
    if (long_hold) hold_req++;
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed bytes: range ends, class boundaries and every escaped class.
    write_slot(CFG_SLOT_FIRST, MODE_CSTYLE);
    write_slot(CFG_SLOT_SECOND, MODE_REGEX);
    write_slot(CFG_SLOT_THIRD, MODE_HEX);
    @(negedge clk);
    text_q = '{8'h00, 8'hFF, 8'h7F, 8'h7E, 8'h1F, 8'h20, 8'h0D, 8'h0A, 8'h09,
               8'h5C, 8'h27, 8'h22, ".", "$", "[", "]", "(", "{", "}", "A"};
    drain();

    // Random phases over the slot settings.
    run_phase(MODE_NONE, MODE_NONE, MODE_NONE, 25, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(MODE_HEX, MODE_REGEX, MODE_CSTYLE, 30, 1'b1, 1'b1, 1'b0, 1'b0);
    run_phase(MODE_REGEX, MODE_CSTYLE, MODE_HEX, 30, 1'b0, 1'b0, 1'b0, 1'b0);
    run_phase(MODE_HEX, MODE_HEX, MODE_HEX, 20, 1'b1, 1'b0, 1'b1, 1'b0);
    run_phase(MODE_NONE, MODE_NONE, MODE_HEX, 25, 1'b0, 1'b1, 1'b1, 1'b0);
    run_phase(MODE_CSTYLE, MODE_NONE, MODE_REGEX, 25, 1'b1, 1'b1, 1'b0, 1'b0);
    // Long hold-off at the output while the input keeps offering bytes.
    run_phase(MODE_CSTYLE, MODE_HEX, MODE_REGEX, 70, 1'b0, 1'b1, 1'b0, 1'b1);
    for (int p = 0; p < 3; p++) begin
      run_phase(esc_mode_t'($urandom_range(0, 3)), esc_mode_t'($urandom_range(0, 3)),
                esc_mode_t'($urandom_range(0, 3)), 30, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    end

    repeat (10) @(posedge clk);
    mismatches += escaped_q.size();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/bee_pkg.sv
hdl/bee_front.sv
hdl/bee_queue.sv
hdl/bee_back.sv
hdl/byte_escape_encoder.sv
test/tb_top.sv
